>>> src/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg - shared definitions for the ring fault diagnosis engine
// Event opcodes, result status codes, diagnosis entry codes, sequencer
// states and counter limits.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // event opcodes
  localparam logic [1:0] OP_TEST    = 2'd0;
  localparam logic [1:0] OP_FAULT   = 2'd1;
  localparam logic [1:0] OP_RECOVER = 2'd2;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_ALREADY = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  // diagnosis table entries
  localparam logic [1:0] DIAG_OK     = 2'd0;
  localparam logic [1:0] DIAG_FAULTY = 2'd1;
  localparam logic [1:0] DIAG_UNDEF  = 2'd2;

  // counters
  localparam int unsigned       CNT_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WALK,
    S_MERGE,
    S_WRITE,
    S_ROUND,
    S_FIN
  } fsm_t;

endpackage

>>> src/rfd_if.sv
// ----------------------------------------------------------------------------
// rfd_if - event and result channels of the ring fault diagnosis engine
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] node;

  modport source (output valid, opcode, node, input ready);
  modport sink   (input valid, opcode, node, output ready);
endinterface

interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  found_node;
  logic [2:0]  faulty_skipped;
  logic        round_done;
  logic [15:0] rounds;
  logic [15:0] tester_tests;
  logic [15:0] state_row;

  modport source (output valid, status, found_node, faulty_skipped, round_done,
                  rounds, tester_tests, state_row, input ready);
  modport sink   (input valid, status, found_node, faulty_skipped, round_done,
                  rounds, tester_tests, state_row, output ready);
endinterface

>>> src/rfd_row_mem.sv
// ----------------------------------------------------------------------------
// rfd_row_mem - diagnosis table storage, one row per node
// One write and one registered read per cycle. A row never written reads
// as its reset value: own entry fault-free, all others undefined.
// ----------------------------------------------------------------------------
module rfd_row_mem #(
  parameter int unsigned NODES = 8,
  parameter int unsigned NW    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [NW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [NW-1:0]         wr_addr,
  input  logic [NODES-1:0][1:0] wr_data,
  output logic [NODES-1:0][1:0] rd_data
);

  logic [NODES-1:0][1:0] mem [NODES];
  logic [NODES-1:0][1:0] rd_q_r;
  logic [NW-1:0]         rd_addr_r;
  logic                  rd_valid_r;
  logic [NODES-1:0]      valid_r;
  logic [NODES-1:0][1:0] init_row;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r    <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // reset row for the registered address
  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      init_row[j] = (NW'(j) == rd_addr_r) ? rfd_pkg::DIAG_OK : rfd_pkg::DIAG_UNDEF;
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : init_row;

endmodule

>>> src/rfd_sat_add.sv
// ----------------------------------------------------------------------------
// rfd_sat_add - shared saturating counter adder
// Adds a small increment to a 16-bit count, clamping at the maximum.
// ----------------------------------------------------------------------------
module rfd_sat_add #(
  parameter int unsigned BW = 4
) (
  input  logic [rfd_pkg::CNT_W-1:0] a,
  input  logic [BW-1:0]             b,
  output logic [rfd_pkg::CNT_W-1:0] y
);

  logic [rfd_pkg::CNT_W:0] sum;

  assign sum = {1'b0, a} + (rfd_pkg::CNT_W+1)'(b);
  assign y   = sum[rfd_pkg::CNT_W] ? rfd_pkg::CNT_MAX : sum[rfd_pkg::CNT_W-1:0];

endmodule

>>> src/ring_fault_diagnosis_engine.sv
// ----------------------------------------------------------------------------
// ring_fault_diagnosis_engine - adaptive diagnosis on a ring of nodes
// Keeps fault flags, a per-node diagnosis table, test and round counters.
//
//   channel  direction  payload
//   in_ch    sink       opcode, node
//   out_ch   source     status, found_node, faulty_skipped, round_done,
//                       rounds, tester_tests, state_row
//
// Fault, recover, unused opcodes and a faulty tester: READ, CHECK, then FIN loads the result.
// A test goes READ, CHECK, WALK once per probe, MERGE only on a find, WRITE, ROUND, FIN.
// One successor per cycle through the shared saturating adder.
// Synchronous active-low reset clears flags, counters and the table's row
// valid bits; no clearing pass is needed. The result sits in an output
// register, so the next event is taken while the result waits for ready.
// ----------------------------------------------------------------------------
module ring_fault_diagnosis_engine #(
  parameter int unsigned NODES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  rfd_in_if.sink    in_ch,
  rfd_out_if.source out_ch
);

  localparam int unsigned NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned PW  = $clog2(NODES + 1);
  localparam int unsigned SRN = (NODES < 8) ? NODES : 8;
  localparam int unsigned CW  = rfd_pkg::CNT_W;

  rfd_pkg::fsm_t state_r, state_nxt;

  logic [1:0]            op_r, op_nxt;
  logic [NW-1:0]         nd_r, nd_nxt;
  logic [NW-1:0]         probe_r, probe_nxt;
  logic [PW-1:0]         probes_r, probes_nxt;
  logic [2:0]            skipped_r, skipped_nxt;
  logic [NW-1:0]         found_r, found_nxt;
  logic                  hit_r, hit_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  done_r, done_nxt;
  logic [NODES-1:0][1:0] own_row_r, own_row_nxt;

  logic [NODES-1:0]         fault_r, fault_nxt;
  logic [NODES-1:0][CW-1:0] tc_r, tc_nxt;
  logic [CW-1:0]            ftally_r, ftally_nxt;
  logic [CW-1:0]            htally_r, htally_nxt;
  logic [CW-1:0]            round_r, round_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [2:0]  out_found_r, out_found_nxt;
  logic [2:0]  out_skipped_r, out_skipped_nxt;
  logic        out_done_r, out_done_nxt;
  logic [15:0] out_rounds_r, out_rounds_nxt;
  logic [15:0] out_tests_r, out_tests_nxt;
  logic [15:0] out_row_r, out_row_nxt;

  logic [NW-1:0]         mem_raddr;
  logic                  mem_we;
  logic [NODES-1:0][1:0] mem_rdata;
  logic [CW-1:0]         add_a;
  logic [PW-1:0]         add_b;
  logic [CW-1:0]         add_y;
  logic [5:0]            nd_red;
  logic [CW:0]           tally_sum;
  logic [15:0]           row_pack;

  // next node around the ring
  function automatic logic [NW-1:0] ring_inc(input logic [NW-1:0] n);
    ring_inc = (n == NW'(NODES - 1)) ? '0 : n + NW'(1);
  endfunction

  // incoming node number modulo NODES: at most three subtract steps
  always_comb begin
    nd_red = {3'b000, in_ch.node};
    for (int k = 0; k < 3; k++) begin
      if (nd_red >= 6'(NODES)) begin
        nd_red = nd_red - 6'(NODES);
      end
    end
  end

  assign tally_sum = {1'b0, ftally_r} + {1'b0, htally_r};

  // pack the tester's row, nodes 0..7 only
  always_comb begin
    row_pack = '0;
    for (int j = 0; j < SRN; j++) begin
      row_pack[2*j +: 2] = own_row_r[j];
    end
  end

  rfd_row_mem #(.NODES(NODES), .NW(NW)) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (mem_raddr),
    .wr_en   (mem_we),
    .wr_addr (nd_r),
    .wr_data (own_row_r),
    .rd_data (mem_rdata)
  );

  rfd_sat_add #(.BW(PW)) u_sat_add (
    .a (add_a),
    .b (add_b),
    .y (add_y)
  );

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    nd_nxt      = nd_r;
    probe_nxt   = probe_r;
    probes_nxt  = probes_r;
    skipped_nxt = skipped_r;
    found_nxt   = found_r;
    hit_nxt     = hit_r;
    status_nxt  = status_r;
    done_nxt    = done_r;
    own_row_nxt = own_row_r;
    fault_nxt   = fault_r;
    tc_nxt      = tc_r;
    ftally_nxt  = ftally_r;
    htally_nxt  = htally_r;
    round_nxt   = round_r;
    mem_raddr   = nd_r;
    mem_we      = 1'b0;
    add_a       = round_r;
    add_b       = PW'(1);

    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_skipped_nxt = out_skipped_r;
    out_done_nxt    = out_done_r;
    out_rounds_nxt  = out_rounds_r;
    out_tests_nxt   = out_tests_r;
    out_row_nxt     = out_row_r;

    unique case (state_r)
      rfd_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          nd_nxt    = nd_red[NW-1:0];
          state_nxt = rfd_pkg::S_READ;
        end
      end
      rfd_pkg::S_READ: begin
        state_nxt = rfd_pkg::S_CHECK;
      end
      rfd_pkg::S_CHECK: begin
        own_row_nxt = mem_rdata;
        status_nxt  = rfd_pkg::ST_OK;
        found_nxt   = '0;
        skipped_nxt = '0;
        done_nxt    = 1'b0;
        hit_nxt     = 1'b0;
        probes_nxt  = '0;
        probe_nxt   = ring_inc(nd_r);
        state_nxt   = rfd_pkg::S_FIN;
        unique case (op_r)
          rfd_pkg::OP_FAULT: begin
            if (fault_r[nd_r]) begin
              status_nxt = rfd_pkg::ST_ALREADY;
            end else begin
              fault_nxt[nd_r] = 1'b1;
            end
          end
          rfd_pkg::OP_RECOVER: begin
            fault_nxt[nd_r] = 1'b0;
          end
          rfd_pkg::OP_TEST: begin
            if (fault_r[nd_r]) begin
              status_nxt = rfd_pkg::ST_SKIPPED;
            end else begin
              state_nxt = rfd_pkg::S_WALK;
            end
          end
          default: ;
        endcase
      end
      // one successor per cycle
      rfd_pkg::S_WALK: begin
        probes_nxt = probes_r + PW'(1);
        if (fault_r[probe_r]) begin
          own_row_nxt[probe_r] = rfd_pkg::DIAG_FAULTY;
          if (skipped_r != 3'd7) begin
            skipped_nxt = skipped_r + 3'd1;
          end
          add_a      = ftally_r;
          ftally_nxt = add_y;
          probe_nxt  = ring_inc(probe_r);
        end else if (probe_r != nd_r) begin
          own_row_nxt[probe_r] = rfd_pkg::DIAG_OK;
          add_a      = htally_r;
          htally_nxt = add_y;
          found_nxt  = probe_r;
          hit_nxt    = 1'b1;
          mem_raddr  = probe_r;
          state_nxt  = rfd_pkg::S_MERGE;
        end else begin
          // walk came back to the tester: remaining probes all count
          probes_nxt = PW'(NODES);
          status_nxt = rfd_pkg::ST_NONE;
          state_nxt  = rfd_pkg::S_WRITE;
        end
      end
      // fill undefined entries from the found node's row
      rfd_pkg::S_MERGE: begin
        for (int j = 0; j < NODES; j++) begin
          if (own_row_r[j] == rfd_pkg::DIAG_UNDEF) begin
            own_row_nxt[j] = mem_rdata[j];
          end
        end
        state_nxt = rfd_pkg::S_WRITE;
      end
      rfd_pkg::S_WRITE: begin
        mem_we       = 1'b1;
        add_a        = tc_r[nd_r];
        add_b        = probes_r;
        tc_nxt[nd_r] = add_y;
        state_nxt    = rfd_pkg::S_ROUND;
      end
      rfd_pkg::S_ROUND: begin
        if (tally_sum == (CW+1)'(NODES)) begin
          add_a      = round_r;
          round_nxt  = add_y;
          ftally_nxt = '0;
          htally_nxt = '0;
          done_nxt   = 1'b1;
        end
        state_nxt = rfd_pkg::S_FIN;
      end
      // load the output register once it is free
      rfd_pkg::S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_found_nxt   = 3'(found_r);
          out_skipped_nxt = skipped_r;
          out_done_nxt    = done_r;
          out_rounds_nxt  = round_r;
          out_tests_nxt   = tc_r[nd_r];
          out_row_nxt     = row_pack;
          state_nxt       = rfd_pkg::S_IDLE;
        end
      end
      default: state_nxt = rfd_pkg::S_IDLE;
    endcase
  end

  // control and diagnosis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfd_pkg::S_IDLE;
      fault_r     <= '0;
      tc_r        <= '0;
      ftally_r    <= '0;
      htally_r    <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fault_r     <= fault_nxt;
      tc_r        <= tc_nxt;
      ftally_r    <= ftally_nxt;
      htally_r    <= htally_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    nd_r          <= nd_nxt;
    probe_r       <= probe_nxt;
    probes_r      <= probes_nxt;
    skipped_r     <= skipped_nxt;
    found_r       <= found_nxt;
    hit_r         <= hit_nxt;
    status_r      <= status_nxt;
    done_r        <= done_nxt;
    own_row_r     <= own_row_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_skipped_r <= out_skipped_nxt;
    out_done_r    <= out_done_nxt;
    out_rounds_r  <= out_rounds_nxt;
    out_tests_r   <= out_tests_nxt;
    out_row_r     <= out_row_nxt;
  end

  assign in_ch.ready           = (state_r == rfd_pkg::S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_node     = out_found_r;
  assign out_ch.faulty_skipped = out_skipped_r;
  assign out_ch.round_done     = out_done_r;
  assign out_ch.rounds         = out_rounds_r;
  assign out_ch.tester_tests   = out_tests_r;
  assign out_ch.state_row      = out_row_r;

`ifndef SYNTHESIS
  // the tester stays fault-free for the whole walk
  a_walk_tester_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfd_pkg::S_WALK |-> !fault_r[nd_r])
    else $error("walk running for a faulty tester");

  // a walk without a find counts every node as probed
  a_miss_probes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfd_pkg::S_WRITE && !hit_r) |-> probes_r == PW'(NODES))
    else $error("missed walk with short probe count");

  // a found node is never the tester itself
  a_found_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfd_pkg::S_WRITE && hit_r) |-> found_r != nd_r)
    else $error("tester found itself");

  // skipped successors never outnumber the probes
  a_skip_le_probes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfd_pkg::S_WRITE |-> (PW+3)'(skipped_r) <= (PW+3)'(probes_r))
    else $error("skip count exceeds probes");

  // the merge always follows a find
  a_merge_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfd_pkg::S_MERGE |-> hit_r && $past(state_r) == rfd_pkg::S_WALK)
    else $error("merge without a find");
`endif

endmodule

>>> tb/sv/ring_fault_diagnosis_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_fault_diagnosis_engine_test - self-checking bench for the diagnosis engine
// Drives fault, recover, test and unused events through the event channel.
// A cycle-free model of the ring (fault flags, diagnosis rows, test and round
// counters) predicts each result, and every result transfer is compared
// field by field. Random gaps, output stalls, a long output hold and a
// run with one lone healthy node cover timing and the corner cases.
// ----------------------------------------------------------------------------
module ring_fault_diagnosis_engine_test;

  localparam int unsigned NODES       = 8;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  found_node;
    logic [2:0]  faulty_skipped;
    logic        round_done;
    logic [15:0] rounds;
    logic [15:0] tester_tests;
    logic [15:0] state_row;
  } diag_result_t;

  logic clk;
  logic rst_n;

  rfd_in_if  in_ch ();
  rfd_out_if out_ch ();

  ring_fault_diagnosis_engine #(.NODES(NODES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ring model state
  logic [NODES-1:0] node_faulty;
  logic [1:0]       diag_row [NODES][NODES];
  logic [15:0]      test_count [NODES];
  logic [15:0]      faulty_finds;
  logic [15:0]      healthy_finds;
  logic [15:0]      round_total;

  diag_result_t pending_results [$];
  int           mismatches;
  bit           quiet;
  logic         hold_request;
  logic         sink_hold;
  int           stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] sat_inc(logic [15:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > rfd_pkg::CNT_MAX) ? rfd_pkg::CNT_MAX : s[15:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_ring();
    for (int i = 0; i < NODES; i++) begin
      node_faulty[i] = 1'b0;
      test_count[i]  = '0;
      for (int j = 0; j < NODES; j++)
        diag_row[i][j] = (i == j) ? rfd_pkg::DIAG_OK : rfd_pkg::DIAG_UNDEF;
    end
    faulty_finds  = '0;
    healthy_finds = '0;
    round_total   = '0;
  endfunction

  // apply one event to the ring model and queue the result it yields
  task automatic diagnose_event(input logic [1:0] op, input logic [2:0] raw_node);
    int unsigned  nd;
    int unsigned  probe;
    int unsigned  probes;
    int unsigned  i;
    int unsigned  j;
    bit           hit;
    logic [15:0]  row;
    diag_result_t r;
    nd = raw_node % NODES;
    r  = '{status: rfd_pkg::ST_OK, found_node: '0, faulty_skipped: '0, round_done: 1'b0,
           rounds: '0, tester_tests: '0, state_row: '0};
    case (op)
      rfd_pkg::OP_FAULT: begin
        if (node_faulty[nd]) r.status = rfd_pkg::ST_ALREADY;
        else node_faulty[nd] = 1'b1;
      end
      rfd_pkg::OP_RECOVER: begin
        node_faulty[nd] = 1'b0;
      end
      rfd_pkg::OP_TEST: begin
        if (node_faulty[nd]) begin
          r.status = rfd_pkg::ST_SKIPPED;
        end else begin
          probe  = (nd + 1) % NODES;
          probes = 0;
          hit    = 1'b0;
          // walk the successors; stops at the first fault-free one
          for (i = 0; i < NODES && !hit; i++) begin
            probes++;
            if (node_faulty[probe]) begin
              diag_row[nd][probe] = rfd_pkg::DIAG_FAULTY;
              if (r.faulty_skipped != 3'd7) r.faulty_skipped++;
              faulty_finds = sat_inc(faulty_finds, 1);
              probe = (probe + 1) % NODES;
            end else if (probe != nd) begin
              diag_row[nd][probe] = rfd_pkg::DIAG_OK;
              healthy_finds = sat_inc(healthy_finds, 1);
              // fill own undefined entries from the found node's row
              for (j = 0; j < NODES; j++)
                if (diag_row[nd][j] == rfd_pkg::DIAG_UNDEF)
                  diag_row[nd][j] = diag_row[probe][j];
              r.found_node = probe[2:0];
              hit = 1'b1;
            end
          end
          test_count[nd] = sat_inc(test_count[nd], probes);
          if (!hit) begin
            r.status     = rfd_pkg::ST_NONE;
            r.found_node = '0;
          end
          if (int'(faulty_finds) + int'(healthy_finds) == NODES) begin
            round_total   = sat_inc(round_total, 1);
            faulty_finds  = '0;
            healthy_finds = '0;
            r.round_done  = 1'b1;
          end
        end
      end
      default: ;
    endcase
    row = '0;
    for (j = 0; j < NODES && j < 8; j++) row[2*j +: 2] = diag_row[nd][j];
    r.rounds       = round_total;
    r.tester_tests = test_count[nd];
    r.state_row    = row;
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // one event transfer; the model is updated when the transfer happens
  task automatic send_event(input logic [1:0] op, input logic [2:0] nd);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.node   <= nd;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    diagnose_event(op, nd);
  endtask

  // stop offering and wait for every expected result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: check each transfer, then pick next ready
  initial begin
    diag_result_t want;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", 16'(out_ch.status), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 16'(out_ch.status), 16'(want.status));
          if (out_ch.found_node !== want.found_node)
            report_mismatch("found_node", 16'(out_ch.found_node), 16'(want.found_node));
          if (out_ch.faulty_skipped !== want.faulty_skipped)
            report_mismatch("faulty_skipped", 16'(out_ch.faulty_skipped),
                            16'(want.faulty_skipped));
          if (out_ch.round_done !== want.round_done)
            report_mismatch("round_done", 16'(out_ch.round_done), 16'(want.round_done));
          if (out_ch.rounds !== want.rounds)
            report_mismatch("rounds", out_ch.rounds, want.rounds);
          if (out_ch.tester_tests !== want.tester_tests)
            report_mismatch("tester_tests", out_ch.tester_tests, want.tester_tests);
          if (out_ch.state_row !== want.state_row)
            report_mismatch("state_row", out_ch.state_row, want.state_row);
        end
      end
      if (!quiet && stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long output hold, counted here
  initial begin
    sink_hold <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    end
  end

  // unused opcode and recover of a healthy node leave state alone
  task automatic test_idle_events();
    send_event(OP_UNUSED, 3'd0);
    send_event(rfd_pkg::OP_RECOVER, 3'd7);
  endtask

  // fault-free ring: one test per node closes a round
  task automatic test_full_round();
    for (int n = 0; n < NODES; n++) send_event(rfd_pkg::OP_TEST, n[2:0]);
  endtask

  // double fault, faulty tester, and a test that passes one faulty node
  task automatic test_fault_handling();
    send_event(rfd_pkg::OP_FAULT, 3'd1);
    send_event(rfd_pkg::OP_FAULT, 3'd1);
    send_event(rfd_pkg::OP_TEST, 3'd1);
    send_event(rfd_pkg::OP_TEST, 3'd0);
  endtask

  // every successor faulty: walk returns to the tester, then one recovers
  task automatic test_no_healthy_successor();
    send_event(rfd_pkg::OP_FAULT, 3'd0);
    send_event(rfd_pkg::OP_FAULT, 3'd2);
    send_event(rfd_pkg::OP_FAULT, 3'd4);
    send_event(rfd_pkg::OP_FAULT, 3'd5);
    send_event(rfd_pkg::OP_FAULT, 3'd6);
    send_event(rfd_pkg::OP_FAULT, 3'd7);
    send_event(rfd_pkg::OP_TEST, 3'd3);
    send_event(rfd_pkg::OP_RECOVER, 3'd4);
    send_event(rfd_pkg::OP_TEST, 3'd3);
  endtask

  // random traffic in stretches with different fault rates
  task automatic test_random_events(input int count);
    int          r;
    int          fault_pct;
    int          healthy [$];
    logic [1:0]  op;
    logic [2:0]  nd;
    fault_pct = 20;
    for (int k = 0; k < count; k++) begin
      if (k % 200 == 0) begin
        fault_pct = ($urandom_range(0, 2) == 0) ? 8 : ($urandom_range(0, 1) ? 25 : 45);
        quiet     = ($urandom_range(0, 4) == 0);
      end
      // sender pause until the engine has answered everything
      if (k % 400 == 399) wait_drained();
      r = $urandom_range(0, 99);
      if (r < fault_pct) op = rfd_pkg::OP_FAULT;
      else if (r < fault_pct + 20) op = rfd_pkg::OP_RECOVER;
      else if (r < fault_pct + 25) op = OP_UNUSED;
      else op = rfd_pkg::OP_TEST;
      nd = 3'($urandom_range(0, 7));
      // testers are mostly fault-free so the walk gets exercised
      if (op == rfd_pkg::OP_TEST && $urandom_range(0, 4) != 0) begin
        healthy.delete();
        for (int n = 0; n < NODES; n++) if (!node_faulty[n]) healthy.push_back(n);
        if (healthy.size() != 0) nd = 3'(healthy[$urandom_range(0, healthy.size() - 1)]);
      end
      send_event(op, nd);
    end
    quiet = 1'b0;
  endtask

  // result side held off while events keep coming; input must stall
  task automatic test_output_backpressure();
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    for (int k = 0; k < 24; k++)
      send_event(($urandom_range(0, 1) != 0) ? rfd_pkg::OP_TEST : rfd_pkg::OP_RECOVER,
                 3'($urandom_range(0, 7)));
    wait_drained();
  endtask

  // node 0 alone healthy: its tests probe the whole ring and find nothing until node 5 recovers
  task automatic test_lone_healthy_node();
    quiet = 1'b1;
    send_event(rfd_pkg::OP_RECOVER, 3'd0);
    for (int n = 1; n < NODES; n++) send_event(rfd_pkg::OP_FAULT, n[2:0]);
    for (int k = 0; k < 24; k++) send_event(rfd_pkg::OP_TEST, 3'd0);
    send_event(rfd_pkg::OP_TEST, 3'd3);
    send_event(rfd_pkg::OP_RECOVER, 3'd5);
    send_event(rfd_pkg::OP_TEST, 3'd0);
    quiet = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= rfd_pkg::OP_TEST;
    in_ch.node   <= '0;
    hold_request <= 1'b0;
    quiet        = 1'b0;
    mismatches   = 0;
    reset_ring();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_events();
    test_full_round();
    test_fault_handling();
    test_no_healthy_successor();
    wait_drained();
    test_random_events(1520);
    test_output_backpressure();
    test_lone_healthy_node();

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
